// ===== hdl/skt_pkg.sv =====
`timescale 1ns / 1ps

package skt_pkg;

  localparam int unsigned DEF_CAPACITY = 32;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned COUNT_W  = 6;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

  // Result of the shared key comparator
  typedef struct packed {
    logic eq;  // search key equals stored entry
    logic gt;  // search key is greater than stored entry (signed)
  } skt_cmp_t;

endpackage

// ===== hdl/skt_ram.sv =====
`timescale 1ns / 1ps

module skt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/skt_cmp.sv =====
`timescale 1ns / 1ps

module skt_cmp
  import skt_pkg::*;
(
  input  logic signed [KEY_W-1:0] key_i,
  input  logic        [KEY_W-1:0] entry_i,
  output skt_cmp_t                res_o
);

  logic signed [KEY_W-1:0] entry_s;

  assign entry_s   = $signed(entry_i);
  assign res_o.eq  = (key_i == entry_s);
  assign res_o.gt  = (key_i > entry_s);

endmodule

// ===== hdl/sorted_key_table.sv =====
`timescale 1ns / 1ps
// Clear, insert into a full or empty table, and search or delete on an empty table go
// straight to the response state. Insert walks down from the top entry, shifting keys up;
// search scans up from entry 0; delete scans, then shifts keys down. One key memory read
// and one compare per cycle. A new transfer waits until the previous result is loaded.
// Reset clears fill count and control only; key memory is not reset and needs no sweep.
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic        [MODE_W-1:0]   mode_i,
  input  logic signed [KEY_W-1:0]    key_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic        [STATUS_W-1:0] status_o,
  output logic        [POS_W-1:0]    position_o,
  output logic        [COUNT_W-1:0]  count_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INS  = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_DEL  = 3'd3;
  localparam logic [2:0] ST_RESP = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [MODE_W-1:0]       mode_q, mode_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]        fill_q, fill_d;
  logic [STATUS_W-1:0]     res_status_q, res_status_d;
  logic [IDX_W-1:0]        res_pos_q, res_pos_d;

  logic                    out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]     out_status_q, out_status_d;
  logic [IDX_W-1:0]        out_pos_q, out_pos_d;
  logic [CNT_W-1:0]        out_cnt_q, out_cnt_d;

  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [KEY_W-1:0]        mem_wdata;
  logic                    mem_re;
  logic [IDX_W-1:0]        mem_raddr;
  logic [KEY_W-1:0]        mem_rdata;

  skt_cmp_t                cmp_res;

  logic [SUM_W-1:0]        idx_p1, idx_p2, fill_w;
  logic [IDX_W-1:0]        idx_m1, idx_m2;

  skt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  skt_cmp u_cmp (
    .key_i   (key_q),
    .entry_i (mem_rdata),
    .res_o   (cmp_res)
  );

  assign idx_p1 = SUM_W'(idx_q) + SUM_W'(1);
  assign idx_p2 = SUM_W'(idx_q) + SUM_W'(2);
  assign fill_w = SUM_W'(fill_q);
  assign idx_m1 = idx_q - IDX_W'(1);
  assign idx_m2 = idx_q - IDX_W'(2);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    key_d        = key_q;
    idx_d        = idx_q;
    fill_d       = fill_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_cnt_d    = out_cnt_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d       = mode_i;
          key_d        = key_i;
          res_status_d = STATUS_OK;
          res_pos_d    = '0;
          idx_d        = '0;
          case (mode_i) inside
            MODE_CLEAR: begin
              fill_d  = '0;
              state_d = ST_RESP;
            end
            MODE_INSERT: begin
              if (fill_q == CNT_W'(CAPACITY)) begin
                res_status_d = STATUS_FULL;
                state_d      = ST_RESP;
              end else if (fill_q == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = key_i;
                fill_d    = CNT_W'(1);
                state_d   = ST_RESP;
              end else begin
                // walk down from the top entry
                idx_d     = IDX_W'(fill_q);
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(fill_q - CNT_W'(1));
                state_d   = ST_INS;
              end
            end
            MODE_SEARCH, MODE_DELETE: begin
              if (fill_q == '0) begin
                res_status_d = STATUS_MISSING;
                state_d      = ST_RESP;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_INS: begin
        // read data holds entry idx-1
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        if (idx_q != '0 && !cmp_res.gt) begin
          mem_wdata = mem_rdata;
          idx_d     = idx_m1;
          if (idx_q != IDX_W'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = idx_m2;
          end
        end else begin
          mem_wdata = key_q;
          fill_d    = fill_q + CNT_W'(1);
          res_pos_d = idx_q;
          state_d   = ST_RESP;
        end
      end

      ST_SCAN: begin
        // read data holds entry idx
        if (cmp_res.eq) begin
          res_pos_d = idx_q;
          if (mode_q == MODE_DELETE) begin
            if (idx_p1 < fill_w) begin
              mem_re    = 1'b1;
              mem_raddr = idx_p1[IDX_W-1:0];
              state_d   = ST_DEL;
            end else begin
              fill_d  = fill_q - CNT_W'(1);
              state_d = ST_RESP;
            end
          end else begin
            state_d = ST_RESP;
          end
        end else if (idx_p1 >= fill_w) begin
          res_status_d = STATUS_MISSING;
          state_d      = ST_RESP;
        end else begin
          idx_d     = idx_p1[IDX_W-1:0];
          mem_re    = 1'b1;
          mem_raddr = idx_p1[IDX_W-1:0];
        end
      end

      ST_DEL: begin
        // close the gap: entry idx takes entry idx+1
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = mem_rdata;
        idx_d     = idx_p1[IDX_W-1:0];
        if (idx_p2 < fill_w) begin
          mem_re    = 1'b1;
          mem_raddr = idx_p2[IDX_W-1:0];
        end else begin
          fill_d  = fill_q - CNT_W'(1);
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = res_pos_q;
          out_cnt_d    = fill_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign position_o  = POS_W'(out_pos_q);
  assign count_o     = COUNT_W'(out_cnt_q);

  // fill count never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // memory writes stay inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (SUM_W'(mem_waddr) < SUM_W'(CAPACITY)))
    else $error("key memory write out of range");

  // a new result only comes from the response state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !(out_valid_q && out_stall_i)) |-> (state_q == ST_RESP))
    else $error("result loaded outside response state");

  // a full report always carries a full count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STATUS_FULL) |-> (out_cnt_q == CNT_W'(CAPACITY)))
    else $error("full status with count below capacity");

  // insert never runs on a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS) |-> (fill_q != CNT_W'(CAPACITY)))
    else $error("insert walk on full table");

endmodule
